>>> src/lsch_pkg.sv
// Shared types and constants of the lottery scheduler.
package lsch_pkg;

  localparam int PID_W       = 6;
  localparam int TICKET_IN_W = 16;
  localparam int RNG_W       = 32;

  localparam logic [RNG_W-1:0] LCG_MUL      = 32'd1103515245;
  localparam logic [RNG_W-1:0] LCG_ADD      = 32'd12345;
  localparam logic [RNG_W-1:0] DEFAULT_SEED = 32'd42;

  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ENQ  = 2'd0,
    STATUS_DROP = 2'd1,
    STATUS_PICK = 2'd2,
    STATUS_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic sum;
    logic cmp;
    logic find;
    logic remove;
  } cell_ctl_t;

endpackage

>>> src/lsch_cell.sv
// One queue slot: pid, tickets, prefix sum, hit flag and pid forward chain.
module lsch_cell #(
  parameter int TICKET_BITS = 16,
  parameter int SUM_W       = 22
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsch_pkg::cell_ctl_t         ctl,
  input  logic [lsch_pkg::PID_W-1:0]  in_pid,
  input  logic [TICKET_BITS-1:0]      in_tk,
  input  logic [SUM_W-1:0]            target,
  input  logic                        prv_valid,
  input  logic [SUM_W-1:0]            prv_psum,
  input  logic                        prv_hit,
  input  logic [lsch_pkg::PID_W-1:0]  prv_fwd,
  input  logic                        nxt_valid,
  input  logic [lsch_pkg::PID_W-1:0]  nxt_pid,
  input  logic [TICKET_BITS-1:0]      nxt_tk,
  output logic                        valid,
  output logic [lsch_pkg::PID_W-1:0]  pid,
  output logic [TICKET_BITS-1:0]      tk,
  output logic [SUM_W-1:0]            psum,
  output logic                        hit,
  output logic [lsch_pkg::PID_W-1:0]  fwd
);

  logic                       valid_r;
  logic [lsch_pkg::PID_W-1:0] pid_r;
  logic [TICKET_BITS-1:0]     tk_r;
  logic [SUM_W-1:0]           psum_r;
  logic                       hit_r;
  logic [lsch_pkg::PID_W-1:0] fwd_r;

  logic take_slot;
  logic shift_in;

  assign take_slot = ctl.enq && !valid_r && prv_valid;
  assign shift_in  = ctl.remove && hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_in) begin
      valid_r <= nxt_valid;
    end else if (take_slot) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      pid_r <= nxt_pid;
      tk_r  <= nxt_tk;
    end else if (take_slot) begin
      pid_r <= in_pid;
      tk_r  <= in_tk;
    end else if (ctl.enq && valid_r && (pid_r == in_pid)) begin
      tk_r <= in_tk;
    end
    if (ctl.sum) begin
      psum_r <= prv_psum + (valid_r ? SUM_W'(tk_r) : '0);
    end
    if (ctl.cmp) begin
      hit_r <= (psum_r > target);
    end
    if (ctl.find) begin
      fwd_r <= (hit_r && !prv_hit) ? pid_r : prv_fwd;
    end
  end

  assign valid = valid_r;
  assign pid   = pid_r;
  assign tk    = tk_r;
  assign psum  = psum_r;
  assign hit   = hit_r;
  assign fwd   = fwd_r;

endmodule

>>> src/lsch_divider.sv
// Restoring radix-2 remainder unit: 32-bit dividend modulo the ticket total.
module lsch_divider #(
  parameter int SUM_W = 22
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lsch_pkg::RNG_W-1:0]  dividend,
  input  logic [SUM_W-1:0]            divisor,
  output logic                        done,
  output logic [SUM_W-1:0]            rem
);

  localparam int CNT_W = $clog2(lsch_pkg::RNG_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lsch_pkg::RNG_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [lsch_pkg::RNG_W-1:0] dvd_r;
  logic [SUM_W-1:0]           rem_r;

  logic [SUM_W:0] trial;
  logic [SUM_W:0] diff;
  logic [SUM_W-1:0] rem_step;

  always_comb begin
    trial = {rem_r, dvd_r[lsch_pkg::RNG_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_step = diff[SUM_W-1:0];
    end else begin
      rem_step = trial[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lsch_pkg::RNG_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> src/lottery_scheduler.sv
// Lottery scheduler top level: cell chain, sequencer, LCG and result register.
//
// An enqueue transaction writes the first free cell of a chain of MAX_QUEUE cells;
// every queued cell with the same pid takes the new ticket count. When the chain is
// full the enqueue is dropped. A pick transaction runs a prefix-sum wave down the
// chain, checks the total and steps the LCG, runs a bit-serial 32-bit modulo, compares
// every prefix sum with the target, walks the chosen pid down the chain and closes
// the gap. A pick with zero total ends after the sum wave and the total check. One
// transaction is in work at a time; a finished result waits in a holding register
// while the output register is still occupied.
module lottery_scheduler #(
  parameter int MAX_QUEUE   = 64,
  parameter int TICKET_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsch_pkg::RNG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [lsch_pkg::PID_W-1:0]     in_pid,
  input  logic [lsch_pkg::TICKET_IN_W-1:0] in_ticket_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lsch_pkg::PID_W-1:0]     out_chosen_pid,
  output logic [1:0]                     out_status
);

  localparam int SUM_W = TICKET_BITS + $clog2(MAX_QUEUE);
  localparam int CNT_W = $clog2(MAX_QUEUE);
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(MAX_QUEUE - 1);

  typedef enum logic [3:0] {
    IDLE, SUM, CHK, DIVST, DIVW, CMP, FIND, REMOVE, HOLD
  } state_t;

  state_t                     st_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [lsch_pkg::RNG_W-1:0] rng_r;
  logic                       out_valid_r;
  logic [lsch_pkg::PID_W-1:0] out_pid_r;
  lsch_pkg::status_t          out_status_r;
  logic [lsch_pkg::PID_W-1:0] res_pid_r;
  lsch_pkg::status_t          res_status_r;

  lsch_pkg::cell_ctl_t ctl;
  logic [TICKET_BITS-1:0] in_tk;
  logic in_acc;
  logic out_free;
  logic out_set;
  logic lcg_step;
  logic full;
  logic div_start;
  logic div_done;
  logic [SUM_W-1:0] div_rem;
  logic [SUM_W-1:0] total;
  logic [lsch_pkg::PID_W-1:0] pick_pid;

  logic                       c_valid [MAX_QUEUE];
  logic [lsch_pkg::PID_W-1:0] c_pid   [MAX_QUEUE];
  logic [TICKET_BITS-1:0]     c_tk    [MAX_QUEUE];
  logic [SUM_W-1:0]           c_psum  [MAX_QUEUE];
  logic                       c_hit   [MAX_QUEUE];
  logic [lsch_pkg::PID_W-1:0] c_fwd   [MAX_QUEUE];

  assign in_tk    = TICKET_BITS'(in_ticket_count);
  assign in_stall = (st_r != IDLE);
  assign in_acc   = in_valid && (st_r == IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = c_valid[MAX_QUEUE-1];
  assign total    = c_psum[MAX_QUEUE-1];
  assign pick_pid = c_fwd[MAX_QUEUE-1];
  assign lcg_step = (st_r == CHK) && (total != '0);

  // output register loaded this cycle
  assign out_set = out_free && ((in_acc && (in_command == lsch_pkg::CMD_ENQ)) ||
                                ((st_r == CHK) && (total == '0)) ||
                                (st_r == REMOVE) || (st_r == HOLD));

  always_comb begin
    ctl        = '0;
    ctl.enq    = in_acc && (in_command == lsch_pkg::CMD_ENQ) && !full;
    ctl.sum    = (st_r == SUM);
    ctl.cmp    = (st_r == CMP);
    ctl.find   = (st_r == FIND);
    ctl.remove = (st_r == REMOVE);
  end

  assign div_start = (st_r == DIVST);

  genvar i;
  generate
    for (i = 0; i < MAX_QUEUE; i++) begin : g_cell
      logic                       p_valid;
      logic [SUM_W-1:0]           p_psum;
      logic                       p_hit;
      logic [lsch_pkg::PID_W-1:0] p_fwd;
      logic                       n_valid;
      logic [lsch_pkg::PID_W-1:0] n_pid;
      logic [TICKET_BITS-1:0]     n_tk;

      if (i == 0) begin : g_head
        assign p_valid = 1'b1;
        assign p_psum  = '0;
        assign p_hit   = 1'b0;
        assign p_fwd   = '0;
      end else begin : g_body
        assign p_valid = c_valid[i-1];
        assign p_psum  = c_psum[i-1];
        assign p_hit   = c_hit[i-1];
        assign p_fwd   = c_fwd[i-1];
      end

      if (i == MAX_QUEUE - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_pid   = '0;
        assign n_tk    = '0;
      end else begin : g_link
        assign n_valid = c_valid[i+1];
        assign n_pid   = c_pid[i+1];
        assign n_tk    = c_tk[i+1];
      end

      lsch_cell #(
        .TICKET_BITS (TICKET_BITS),
        .SUM_W       (SUM_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_pid    (in_pid),
        .in_tk     (in_tk),
        .target    (div_rem),
        .prv_valid (p_valid),
        .prv_psum  (p_psum),
        .prv_hit   (p_hit),
        .prv_fwd   (p_fwd),
        .nxt_valid (n_valid),
        .nxt_pid   (n_pid),
        .nxt_tk    (n_tk),
        .valid     (c_valid[i]),
        .pid       (c_pid[i]),
        .tk        (c_tk[i]),
        .psum      (c_psum[i]),
        .hit       (c_hit[i]),
        .fwd       (c_fwd[i])
      );
    end
  endgenerate

  lsch_divider #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rng_r),
    .divisor  (total),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= lsch_pkg::DEFAULT_SEED;
    end else if (cfg_we) begin
      rng_r <= (cfg_wdata == '0) ? lsch_pkg::DEFAULT_SEED : cfg_wdata;
    end else if (lcg_step) begin
      rng_r <= rng_r * lsch_pkg::LCG_MUL + lsch_pkg::LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      out_pid_r    <= '0;
      out_status_r <= lsch_pkg::STATUS_ENQ;
      res_pid_r    <= '0;
      res_status_r <= lsch_pkg::STATUS_ENQ;
    end else begin
      if (out_valid_r && !out_stall && !out_set) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        IDLE: begin
          if (in_acc) begin
            if (in_command == lsch_pkg::CMD_PICK) begin
              st_r  <= SUM;
              cnt_r <= '0;
            end else if (out_free) begin
              out_valid_r  <= 1'b1;
              out_pid_r    <= '0;
              out_status_r <= full ? lsch_pkg::STATUS_DROP : lsch_pkg::STATUS_ENQ;
            end else begin
              res_pid_r    <= '0;
              res_status_r <= full ? lsch_pkg::STATUS_DROP : lsch_pkg::STATUS_ENQ;
              st_r         <= HOLD;
            end
          end
        end
        SUM: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_CELL) begin
            st_r <= CHK;
          end
        end
        CHK: begin
          if (total == '0) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_pid_r    <= '0;
              out_status_r <= lsch_pkg::STATUS_NONE;
              st_r         <= IDLE;
            end else begin
              res_pid_r    <= '0;
              res_status_r <= lsch_pkg::STATUS_NONE;
              st_r         <= HOLD;
            end
          end else begin
            st_r <= DIVST;
          end
        end
        DIVST: begin
          st_r <= DIVW;
        end
        DIVW: begin
          if (div_done) begin
            st_r <= CMP;
          end
        end
        CMP: begin
          st_r  <= FIND;
          cnt_r <= '0;
        end
        FIND: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_CELL) begin
            st_r <= REMOVE;
          end
        end
        REMOVE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pid_r    <= pick_pid;
            out_status_r <= lsch_pkg::STATUS_PICK;
            st_r         <= IDLE;
          end else begin
            res_pid_r    <= pick_pid;
            res_status_r <= lsch_pkg::STATUS_PICK;
            st_r         <= HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pid_r    <= res_pid_r;
            out_status_r <= res_status_r;
            st_r         <= IDLE;
          end
        end
        default: begin
          st_r <= IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chosen_pid = out_pid_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_hold_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == HOLD) |-> out_valid_r)
    else $error("holding a result while the output register is empty");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == DIVW))
    else $error("modulo finished outside its wait state");

  a_remove_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.remove |=> !c_valid[MAX_QUEUE-1])
    else $error("last cell still valid after a removal");

  a_seed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (rng_r != '0))
    else $error("generator state zero after a seed write");
`endif

endmodule

>>> tb/sv/tb.sv
// Lottery scheduler testbench: draw scoreboard class, stimulus tasks and top module.

class draw_board #(int DEPTH = 64, int TK_W = 16);

  typedef struct {
    logic [lsch_pkg::PID_W-1:0] pid;
    lsch_pkg::status_t          status;
  } grant_t;

  logic [lsch_pkg::PID_W-1:0] ready_q[$];
  logic [TK_W-1:0]            tickets [64];
  logic [lsch_pkg::RNG_W-1:0] lcg;
  grant_t                     grants_due[$];
  int                         errors;

  function new();
    lcg    = lsch_pkg::DEFAULT_SEED;
    errors = 0;
  endfunction

  function void load_seed(logic [lsch_pkg::RNG_W-1:0] seed);
    lcg = (seed == '0) ? lsch_pkg::DEFAULT_SEED : seed;
  endfunction

  function int pending();
    return grants_due.size();
  endfunction

  function void take_request(logic cmd, logic [lsch_pkg::PID_W-1:0] pid,
                             logic [lsch_pkg::TICKET_IN_W-1:0] tk);
    grant_t            g;
    longint unsigned   total;
    longint unsigned   target;
    longint unsigned   running;
    int                idx;
    int                k;
    bit                found;
    g.pid    = '0;
    g.status = lsch_pkg::STATUS_ENQ;
    if (cmd == lsch_pkg::CMD_ENQ) begin
      if (ready_q.size() < DEPTH) begin
        ready_q.push_back(pid);
        tickets[pid] = TK_W'(tk);
      end else begin
        g.status = lsch_pkg::STATUS_DROP;
      end
    end else begin
      total = 0;
      for (k = 0; k < ready_q.size(); k++) total += tickets[ready_q[k]];
      if (total == 0) begin
        g.status = lsch_pkg::STATUS_NONE;
      end else begin
        lcg     = lcg * lsch_pkg::LCG_MUL + lsch_pkg::LCG_ADD;
        target  = {32'b0, lcg} % total;
        running = 0;
        found   = 1'b0;
        idx     = ready_q.size() - 1;
        for (k = 0; k < ready_q.size(); k++) begin
          if (!found) begin
            running += tickets[ready_q[k]];
            if (running > target) begin
              idx   = k;
              found = 1'b1;
            end
          end
        end
        g.pid    = ready_q[idx];
        g.status = lsch_pkg::STATUS_PICK;
        ready_q.delete(idx);
      end
    end
    grants_due.push_back(g);
  endfunction

  function void check_grant(logic [lsch_pkg::PID_W-1:0] pid, logic [1:0] status);
    grant_t g;
    if (grants_due.size() == 0) begin
      $error("unexpected transaction: chosen_pid %0d status %0d", pid, status);
      errors++;
    end else begin
      g = grants_due.pop_front();
      if (pid !== g.pid) begin
        $error("chosen_pid: expected %0d, got %0d", g.pid, pid);
        errors++;
      end
      if (status !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, status);
        errors++;
      end
    end
  endfunction

  function void check_drained();
    if (grants_due.size() != 0) begin
      $error("%0d results never arrived", grants_due.size());
      errors++;
    end
  endfunction

endclass

module tb;

  localparam int PID_W          = lsch_pkg::PID_W;
  localparam int RNG_W          = lsch_pkg::RNG_W;
  localparam int TICKET_IN_W    = lsch_pkg::TICKET_IN_W;
  localparam int QUEUE_DEPTH    = 64;
  localparam int TICKET_W       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 200;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   cfg_we          = 1'b0;
  logic [RNG_W-1:0]       cfg_wdata       = '0;
  logic                   in_valid        = 1'b0;
  logic                   in_stall;
  logic                   in_command      = lsch_pkg::CMD_ENQ;
  logic [PID_W-1:0]       in_pid          = '0;
  logic [TICKET_IN_W-1:0] in_ticket_count = '0;
  logic                   out_valid;
  logic                   out_stall       = 1'b0;
  logic [PID_W-1:0]       out_chosen_pid;
  logic [1:0]             out_status;

  draw_board #(QUEUE_DEPTH, TICKET_W) sb;

  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  lottery_scheduler #(
    .MAX_QUEUE  (QUEUE_DEPTH),
    .TICKET_BITS(TICKET_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pid         (in_pid),
    .in_ticket_count(in_ticket_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_chosen_pid (out_chosen_pid),
    .out_status     (out_status)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else if (stall_mode == 2) begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end else begin
      out_stall <= 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.load_seed(cfg_wdata);
      if (in_valid && !in_stall) sb.take_request(in_command, in_pid, in_ticket_count);
      if (out_valid && !out_stall) sb.check_grant(out_chosen_pid, out_status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [PID_W-1:0] rand_pid();
    if ($urandom_range(0, 3) == 0) return PID_W'($urandom_range(0, 3));
    return PID_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [TICKET_IN_W-1:0] rand_tickets();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return TICKET_IN_W'($urandom_range(1, 15));
      3:       return 16'd1 << $urandom_range(0, 15);
      default: return TICKET_IN_W'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic cmd, input logic [PID_W-1:0] pid,
                           input logic [TICKET_IN_W-1:0] tk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_pid          <= pid;
    in_ticket_count <= tk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_seed(input logic [RNG_W-1:0] seed);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic pick();
    push_item(lsch_pkg::CMD_PICK, PID_W'($urandom_range(0, 63)), TICKET_IN_W'($urandom));
  endtask

  task automatic run_directed();
    pick();                            // empty queue
    push_item(lsch_pkg::CMD_ENQ, 6'd5, 16'd0);
    pick();                            // zero total
    push_item(lsch_pkg::CMD_ENQ, 6'd63, 16'hFFFF);
    push_item(lsch_pkg::CMD_ENQ, 6'd0, 16'd1);
    push_item(lsch_pkg::CMD_ENQ, 6'd5, 16'd300); // repeated pid
    repeat (5) pick();
    set_seed(32'hFFFF_FFFF);
    push_item(lsch_pkg::CMD_ENQ, 6'd42, 16'hFFFF);
    push_item(lsch_pkg::CMD_ENQ, 6'd21, 16'h8000);
    push_item(lsch_pkg::CMD_ENQ, 6'd42, 16'd1);
    repeat (3) pick();
  endtask

  task automatic run_random(input int budget);
    int n;
    int kind;
    int len;
    int enq_pct;
    n = 0;
    while (n < budget) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(8, 80);
      if (len > budget - n) len = budget - n;
      if (kind < 3) enq_pct = 92;
      else if (kind < 6) enq_pct = 10;
      else enq_pct = 50;
      if ($urandom_range(0, 11) == 0) wait_idle();
      repeat (len) begin
        push_item(($urandom_range(0, 99) < enq_pct) ? lsch_pkg::CMD_ENQ : lsch_pkg::CMD_PICK,
                  rand_pid(), rand_tickets());
        n++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    set_seed(32'd1);
    run_random(220);
    set_seed($urandom);
    run_random(220);
    set_seed(32'd0);
    run_random(220);
    set_seed(32'hFFFF_FFFF);
    run_random(220);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
